/* hw/rtl/dtds_pkg.sv */
// Shared types, constants and tables for the date/time difference block.
package dtds_pkg;

  localparam int unsigned DAY_W    = 5;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MINUTE_W = 6;
  localparam int unsigned SEC_W    = 6;

  // Day count from year 0 fits in 23 bits; one sign bit covers day zero.
  localparam int unsigned DAYS_W   = 24;
  // Time of day with out-of-range hour/minute/second fields.
  localparam int unsigned TOD_W    = 17;
  localparam int unsigned SECS_W   = 40;
  localparam int unsigned DBM_W    = 9;

  // Reciprocal of 100 for dividends below 2**15.
  localparam int unsigned RECIP_SHIFT = 21;
  localparam int unsigned RECIP_W     = 15;
  localparam logic [RECIP_W-1:0] RECIP_100 = 15'd20972;
  localparam int unsigned DIVQ_W      = 8;
  localparam int unsigned DIVIN_W     = 15;

  localparam logic [DIVIN_W-1:0] HUNDRED  = 15'd100;
  localparam logic [MONTH_W-1:0] FEBRUARY = 4'd2;
  localparam logic [SECS_W-1:0]  SECS_PER_DAY = 40'd86400;

  typedef struct packed {
    logic [DAY_W-1:0]    day;
    logic [MONTH_W-1:0]  month;
    logic [YEAR_W-1:0]   year;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SEC_W-1:0]    sec;
  } ts_t;

  // Days before the month in a common year; month zero acts as January,
  // months past December add 31 days each.
  function automatic logic [DBM_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
    logic [DBM_W-1:0] d;
    case (m)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      4'd13:   d = 9'd365;
      4'd14:   d = 9'd396;
      default: d = 9'd427;
    endcase
    return d;
  endfunction

endpackage

/* hw/rtl/dtds_lane.sv */
// One conversion lane: timestamp to seconds since the start of year 0.
module dtds_lane
  import dtds_pkg::*;
(
  input  logic                     clk,
  input  ts_t                      ts,
  output logic signed [SECS_W-1:0] secs
);

  // Stage 1: divisions by 100 through the reciprocal, time of day.
  logic [DIVIN_W-1:0]           div_a, div_b, div_y;
  logic [DIVIN_W+RECIP_W-1:0]   prod_a, prod_b, prod_y;
  logic [TOD_W-1:0]             tod_nxt;
  logic [YEAR_W-1:0]            y_r;
  logic [MONTH_W-1:0]           m_r;
  logic [DAY_W-1:0]             d_r;
  logic [TOD_W-1:0]             tod_r;
  logic [DIVQ_W-1:0]            qa_r, qb_r, qy_r;

  always_comb begin
    div_a  = DIVIN_W'(ts.year) + 15'd99;
    div_b  = (DIVIN_W'(ts.year) + 15'd399) >> 2;
    div_y  = DIVIN_W'(ts.year);
    prod_a = (DIVIN_W+RECIP_W)'(div_a) * (DIVIN_W+RECIP_W)'(RECIP_100);
    prod_b = (DIVIN_W+RECIP_W)'(div_b) * (DIVIN_W+RECIP_W)'(RECIP_100);
    prod_y = (DIVIN_W+RECIP_W)'(div_y) * (DIVIN_W+RECIP_W)'(RECIP_100);
    tod_nxt = TOD_W'(ts.hour) * 17'd3600 + TOD_W'(ts.minute) * 17'd60 + TOD_W'(ts.sec);
  end

  always_ff @(posedge clk) begin
    y_r   <= ts.year;
    m_r   <= ts.month;
    d_r   <= ts.day;
    tod_r <= tod_nxt;
    qa_r  <= prod_a[RECIP_SHIFT +: DIVQ_W];
    qb_r  <= prod_b[RECIP_SHIFT +: DIVQ_W];
    qy_r  <= prod_y[RECIP_SHIFT +: DIVQ_W];
  end

  // Stage 2: day count and leap-day correction.
  logic [DIVIN_W-1:0]      cent;
  logic                    div100, leap;
  logic [DAYS_W-1:0]       pos_days;
  logic signed [DAYS_W-1:0] days_nxt, days_r;
  logic [TOD_W-1:0]        tod2_r;

  always_comb begin
    cent   = DIVIN_W'(qy_r) * HUNDRED;
    div100 = (DIVIN_W'(y_r) == cent);
    leap   = ((y_r[1:0] == 2'b00) && !div100) || (div100 && (qy_r[1:0] == 2'b00));
    pos_days = DAYS_W'(y_r) * 24'd365
             + DAYS_W'((DIVIN_W'(y_r) + 15'd3) >> 2)
             - DAYS_W'(qa_r) + DAYS_W'(qb_r)
             + DAYS_W'(days_before_month(m_r))
             + DAYS_W'(leap && (m_r > FEBRUARY))
             + DAYS_W'(d_r);
    days_nxt = $signed(pos_days) - 24'sd1;
  end

  always_ff @(posedge clk) begin
    days_r <= days_nxt;
    tod2_r <= tod_r;
  end

  // Stage 3: scale to seconds.
  logic signed [SECS_W-1:0] secs_nxt, secs_r;

  always_comb begin
    secs_nxt = SECS_W'(days_r) * $signed(SECS_PER_DAY) + $signed(SECS_W'(tod2_r));
  end

  always_ff @(posedge clk) begin
    secs_r <= secs_nxt;
  end

  assign secs = secs_r;

endmodule

/* hw/rtl/dtds_merge.sv */
// Merge stage: second lane minus first lane, registered with its strobe.
module dtds_merge
  import dtds_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     vld_in,
  input  logic signed [SECS_W-1:0] secs_a,
  input  logic signed [SECS_W-1:0] secs_b,
  output logic                     out_valid,
  output logic signed [SECS_W-1:0] diff
);

  logic                     vld_r;
  logic signed [SECS_W-1:0] diff_r, diff_nxt;

  assign diff_nxt = secs_b - secs_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    diff_r <= diff_nxt;
  end

  assign out_valid = vld_r;
  assign diff      = diff_r;

  a_strobe_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(vld_in))
    else $error("result strobe without a word in the merge stage");

  a_equal_lanes_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_in && (secs_a == secs_b)) |=> (diff == '0))
    else $error("equal lane values gave a nonzero difference");

endmodule

/* hw/rtl/date_time_difference_seconds.sv */
// Top level: two timestamps in, their difference in seconds out.
// Takes one word on every clock (busy is always low) and returns its result,
// strobed by out_valid for one cycle, after the pipeline: reciprocal
// divisions, day count, scaling by 86400 in each of the two conversion
// lanes, then the subtracting stage. The receiver cannot stall, and none is
// needed since each word yields one result and the pipeline never holds.
module date_time_difference_seconds
  import dtds_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [DAY_W-1:0]         in_first_day,
  input  logic [MONTH_W-1:0]       in_first_month,
  input  logic [YEAR_W-1:0]        in_first_year,
  input  logic [HOUR_W-1:0]        in_first_hour,
  input  logic [MINUTE_W-1:0]      in_first_minute,
  input  logic [SEC_W-1:0]         in_first_second,
  input  logic [DAY_W-1:0]         in_second_day,
  input  logic [MONTH_W-1:0]       in_second_month,
  input  logic [YEAR_W-1:0]        in_second_year,
  input  logic [HOUR_W-1:0]        in_second_hour,
  input  logic [MINUTE_W-1:0]      in_second_minute,
  input  logic [SEC_W-1:0]         in_second_sec,
  output logic                     out_valid,
  output logic signed [SECS_W-1:0] out_difference_seconds
);

  ts_t                      ts_a, ts_b;
  logic signed [SECS_W-1:0] secs_a, secs_b;
  logic [2:0]               vld_r, vld_nxt;
  logic                     accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign ts_a = '{day: in_first_day, month: in_first_month, year: in_first_year,
                  hour: in_first_hour, minute: in_first_minute, sec: in_first_second};
  assign ts_b = '{day: in_second_day, month: in_second_month, year: in_second_year,
                  hour: in_second_hour, minute: in_second_minute, sec: in_second_sec};

  // Advance the strobe alongside the three lane stages.
  assign vld_nxt = {vld_r[1:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  dtds_lane u_lane_a (
    .clk  (clk),
    .ts   (ts_a),
    .secs (secs_a)
  );

  dtds_lane u_lane_b (
    .clk  (clk),
    .ts   (ts_b),
    .secs (secs_b)
  );

  dtds_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .vld_in    (vld_r[2]),
    .secs_a    (secs_a),
    .secs_b    (secs_b),
    .out_valid (out_valid),
    .diff      (out_difference_seconds)
  );

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 4))
    else $error("result strobe without an accepted word four cycles earlier");

  a_same_stamp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(ts_a == ts_b, 4) |-> (out_difference_seconds == '0))
    else $error("identical timestamps gave a nonzero difference");

endmodule

/* dv/tb.sv */
// Testbench for date_time_difference_seconds: directed and random timestamp pairs, scoreboarded.
module tb
  import dtds_pkg::*;
();

  localparam int IDLE_PCT    = 8;
  localparam int STALL_LIMIT = 200;
  localparam int TAIL_CYCLES = 10;
  localparam int MAX_PRINTS  = 100;
  localparam longint DAY_SECS  = 86400;
  localparam longint HOUR_SECS = 3600;
  localparam longint MIN_SECS  = 60;
  // Common-year day offsets; month zero behaves as January, months past
  // December keep adding 31 days.
  localparam int MONTH_START [16] = '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273,
                                      304, 334, 365, 396, 427};

  typedef struct packed {
    ts_t from_ts;
    ts_t to_ts;
  } stamp_pair_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic out_valid;
  logic signed [SECS_W-1:0] out_difference_seconds;
  stamp_pair_t drv_word = '0;
  logic took = 1'b0;
  logic steady = 1'b0;
  int mismatches = 0;
  int stall_cycles = 0;
  int outstanding = 0;
  stamp_pair_t pending_words[$];
  logic [SECS_W-1:0] expected_diffs[$];
  logic [SECS_W-1:0] want_diff;
  wire word_taken = rst_n && (start === 1'b1) && (busy === 1'b0);
  wire diff_seen  = rst_n && (out_valid === 1'b1);

  date_time_difference_seconds DUT (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .start                  (start),
    .busy                   (busy),
    .in_first_day           (drv_word.from_ts.day),
    .in_first_month         (drv_word.from_ts.month),
    .in_first_year          (drv_word.from_ts.year),
    .in_first_hour          (drv_word.from_ts.hour),
    .in_first_minute        (drv_word.from_ts.minute),
    .in_first_second        (drv_word.from_ts.sec),
    .in_second_day          (drv_word.to_ts.day),
    .in_second_month        (drv_word.to_ts.month),
    .in_second_year         (drv_word.to_ts.year),
    .in_second_hour         (drv_word.to_ts.hour),
    .in_second_minute       (drv_word.to_ts.minute),
    .in_second_sec          (drv_word.to_ts.sec),
    .out_valid              (out_valid),
    .out_difference_seconds (out_difference_seconds)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit leap_year(longint y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic longint stamp_seconds(ts_t s);
    longint y, m, d, h, mi, sc, days;
    y = longint'(s.year);
    m = longint'(s.month);
    d = longint'(s.day);
    h = longint'(s.hour);
    mi = longint'(s.minute);
    sc = longint'(s.sec);
    days = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400 + MONTH_START[s.month];
    if (m > 2 && leap_year(y)) days++;
    // day zero lands one day before the month
    days += d - 1;
    return days * DAY_SECS + h * HOUR_SECS + mi * MIN_SECS + sc;
  endfunction

  function automatic logic [SECS_W-1:0] predict_difference(stamp_pair_t p);
    longint diff;
    diff = stamp_seconds(p.to_ts) - stamp_seconds(p.from_ts);
    return diff[SECS_W-1:0];
  endfunction

  function automatic ts_t stamp(int d, int mo, int y, int h, int mi, int s);
    ts_t t;
    t.day = DAY_W'(d);
    t.month = MONTH_W'(mo);
    t.year = YEAR_W'(y);
    t.hour = HOUR_W'(h);
    t.minute = MINUTE_W'(mi);
    t.sec = SEC_W'(s);
    return t;
  endfunction

  function automatic ts_t legal_stamp();
    int y;
    // favor century boundaries where the leap rule turns
    if ($urandom_range(3) == 0) y = $urandom_range(99) * 100 + $urandom_range(4);
    else y = $urandom_range(9999);
    return stamp($urandom_range(1, 31), $urandom_range(1, 12), y, $urandom_range(23),
                 $urandom_range(59), $urandom_range(59));
  endfunction

  function automatic ts_t wild_stamp();
    return stamp($urandom_range(31), $urandom_range(15), $urandom_range(16383),
                 $urandom_range(31), $urandom_range(63), $urandom_range(63));
  endfunction

  function automatic stamp_pair_t random_pair();
    stamp_pair_t p;
    int pick;
    int yr;
    pick = $urandom_range(99);
    p.from_ts = legal_stamp();
    if (pick < 12) begin
      p.from_ts = wild_stamp();
      p.to_ts = wild_stamp();
    end else if (pick < 20) begin
      p.to_ts = wild_stamp();
    end else if (pick < 55) begin
      // keep the pair within a few years of each other
      p.to_ts = p.from_ts;
      yr = int'(p.from_ts.year) + int'($urandom_range(8)) - 4;
      if (yr < 0) yr = 0;
      if (yr > 9999) yr = 9999;
      p.to_ts.year = YEAR_W'(yr);
      p.to_ts.month = MONTH_W'($urandom_range(1, 12));
      p.to_ts.day = DAY_W'($urandom_range(1, 31));
      p.to_ts.hour = HOUR_W'($urandom_range(23));
    end else begin
      p.to_ts = legal_stamp();
    end
    return p;
  endfunction

  task automatic add_pair(ts_t a, ts_t b);
    stamp_pair_t p;
    p.from_ts = a;
    p.to_ts = b;
    pending_words.push_back(p);
  endtask

  task automatic fill_random(int n);
    repeat (n) pending_words.push_back(random_pair());
  endtask

  // Hold until every queued word is taken and its result has come back.
  task automatic drain();
    @(posedge clk);
    while (pending_words.size() != 0 || start || outstanding != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(string what, logic [SECS_W-1:0] want,
                                 logic [SECS_W-1:0] got);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("mismatch: %s expected %0d got %0d at %0t", what, $signed(want),
               $signed(got), $time);
  endtask

  always @(negedge clk) begin
    if (rst_n && (!start || took)) begin
      if (pending_words.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
        drv_word <= pending_words.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    took <= word_taken;
    if (word_taken) expected_diffs.push_back(predict_difference(drv_word));
    if (diff_seen) begin
      if (expected_diffs.size() == 0) begin
        report_mismatch("result with nothing pending", '0, out_difference_seconds);
      end else begin
        want_diff = expected_diffs.pop_front();
        if (out_difference_seconds !== want_diff)
          report_mismatch("difference_seconds", want_diff, out_difference_seconds);
      end
    end
    outstanding <= outstanding + int'(word_taken) - int'(diff_seen && outstanding != 0);
    if (rst_n) begin
      if (word_taken || diff_seen) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // range extremes, both signs, zero
    add_pair(stamp(1, 1, 0, 0, 0, 0), stamp(31, 12, 9999, 23, 59, 59));
    add_pair(stamp(31, 12, 9999, 23, 59, 59), stamp(1, 1, 0, 0, 0, 0));
    add_pair(stamp(15, 6, 2024, 12, 30, 45), stamp(15, 6, 2024, 12, 30, 45));
    // leap rule: year zero, century, four-century
    add_pair(stamp(28, 2, 0, 0, 0, 0), stamp(1, 3, 0, 0, 0, 0));
    add_pair(stamp(28, 2, 1900, 0, 0, 0), stamp(1, 3, 1900, 0, 0, 0));
    add_pair(stamp(28, 2, 2000, 0, 0, 0), stamp(1, 3, 2000, 0, 0, 0));
    add_pair(stamp(1, 3, 2100, 0, 0, 0), stamp(1, 3, 2104, 0, 0, 0));
    add_pair(stamp(1, 1, 1600, 0, 0, 0), stamp(1, 1, 2000, 0, 0, 0));
    add_pair(stamp(31, 12, 1999, 23, 59, 59), stamp(1, 1, 2000, 0, 0, 0));
    // day zero, month zero, months past December
    add_pair(stamp(1, 1, 1, 0, 0, 0), stamp(0, 1, 1, 0, 0, 0));
    add_pair(stamp(1, 1, 2023, 5, 0, 0), stamp(1, 0, 2023, 5, 0, 0));
    add_pair(stamp(1, 12, 2023, 0, 0, 0), stamp(1, 13, 2024, 0, 0, 0));
    add_pair(stamp(5, 14, 2000, 0, 0, 0), stamp(5, 15, 2000, 0, 0, 0));
    // time of day over range, unchecked day of month
    add_pair(stamp(1, 1, 2000, 0, 0, 0), stamp(1, 1, 2000, 31, 63, 63));
    add_pair(stamp(31, 2, 2001, 0, 0, 0), stamp(1, 3, 2001, 0, 0, 0));
    // years past 9999 and every field at its widest
    add_pair(stamp(1, 1, 9999, 0, 0, 0), stamp(1, 1, 16383, 0, 0, 0));
    add_pair(stamp(0, 0, 0, 0, 0, 0), stamp(31, 15, 16383, 31, 63, 63));
    add_pair(stamp(31, 15, 16383, 31, 63, 63), stamp(0, 0, 0, 0, 0, 0));
    drain();

    fill_random(150);
    drain();
    steady = 1'b1;
    fill_random(150);
    drain();
    steady = 1'b0;
    fill_random(150);
    drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_diffs.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/dtds_pkg.sv
hw/rtl/dtds_lane.sv
hw/rtl/dtds_merge.sv
hw/rtl/date_time_difference_seconds.sv
dv/tb.sv
